### hw/rtl/reslu_pkg.sv
package reslu_pkg;

    localparam int SLOTS      = 10;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int HANDLE_W   = 32;
    localparam int SIZE_W     = 16;
    localparam int OFFSET_W   = 20;
    localparam int SLOT_W     = 4;

    localparam int IN_FIELDS_W  = HANDLE_W + SIZE_W + OFFSET_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + SLOT_W + HANDLE_W + SIZE_W + 1 + HANDLE_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_FIND = 1'b1
    } cmd_t;

    typedef logic [IDX_W-1:0] idx_t;

    function automatic idx_t next_slot(input idx_t i);
        return (i == idx_t'(SLOTS - 1)) ? '0 : i + idx_t'(1);
    endfunction

endpackage

### hw/rtl/ring_entry_store_offset_lookup.sv
// Channel   Dir  Beat contents
// s_        in   tuser: command; tdata: entry_handle, entry_size, byte_pos
// m_        out  tdata: hit, slot, handle, byte_offset, evicted, evicted_handle
//
// Add reads the slot being overwritten, then writes it.
// Find steps through the ring one entry per cycle through the
// shared compare/subtract unit, fed by the registered read of the slot memory.
// One item at a time; s_tready is high only while idle.
// A result waits in the output register; the next item is taken meanwhile.
// Reset clears indices, full flag, valid bits and the output valid.
module ring_entry_store_offset_lookup import reslu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] entry_handle, [47:32] entry_size, [67:48] byte_pos
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [0] command
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] hit, [4:1] slot, [36:5] handle, [52:37] byte_offset,
    // [53] evicted, [85:54] evicted_handle
    output logic [OUT_DATA_W-1:0] m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_WALK
    } state_t;

    state_t                state_reg;
    idx_t                  write_index_reg;
    idx_t                  read_index_reg;
    logic                  ring_full_reg;
    logic [SLOTS-1:0]      slot_valid_reg;

    idx_t                  cur_reg;
    idx_t                  start_reg;
    logic [OFFSET_W-1:0]   off_reg;
    logic [HANDLE_W-1:0]   add_handle_reg;
    logic [SIZE_W-1:0]     add_size_reg;

    logic [HANDLE_W-1:0]   handle_mem [SLOTS];
    logic [SIZE_W-1:0]     len_mem    [SLOTS];
    logic [HANDLE_W-1:0]   rd_handle_reg;
    logic [SIZE_W-1:0]     rd_len_reg;

    logic                  m_tvalid_reg;
    logic                  out_hit_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [HANDLE_W-1:0]   out_handle_reg;
    logic [SIZE_W-1:0]     out_offset_reg;
    logic                  out_evicted_reg;
    logic [HANDLE_W-1:0]   out_evicted_handle_reg;

    logic                  accept;
    logic                  out_free;
    logic                  out_load;
    logic                  cur_valid;
    logic                  step;
    logic                  wrap;
    idx_t                  nxt;
    idx_t                  rd_addr;
    logic                  mem_we;
    idx_t                  add_nxt;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // shared compare/subtract: skip this entry if the offset lies past it
    assign cur_valid = slot_valid_reg[cur_reg];
    assign step      = cur_valid && (off_reg >= OFFSET_W'(rd_len_reg));
    assign nxt       = next_slot(cur_reg);
    assign wrap      = (nxt == start_reg);
    assign add_nxt   = next_slot(write_index_reg);
    assign mem_we    = (state_reg == ST_ADD) && out_free;
    assign out_load  = out_free && ((state_reg == ST_ADD) ||
                                    ((state_reg == ST_WALK) && !(step && !wrap)));

    // address for next cycle's registered read; hold on the current entry when stalled
    always_comb begin
        unique case (state_reg)
            ST_IDLE: rd_addr = (cmd_t'(s_tuser[0]) == CMD_ADD) ? write_index_reg
                                                               : read_index_reg;
            ST_ADD:  rd_addr = write_index_reg;
            ST_WALK: rd_addr = (step && !wrap) ? nxt : cur_reg;
            default: rd_addr = cur_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_handle_reg <= handle_mem[rd_addr];
        rd_len_reg    <= len_mem[rd_addr];
        if (mem_we) begin
            handle_mem[write_index_reg] <= add_handle_reg;
            len_mem[write_index_reg]    <= add_size_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            write_index_reg <= '0;
            read_index_reg  <= '0;
            ring_full_reg   <= 1'b0;
            slot_valid_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        add_handle_reg <= s_tdata[HANDLE_W-1:0];
                        add_size_reg   <= s_tdata[HANDLE_W+SIZE_W-1:HANDLE_W];
                        off_reg        <= s_tdata[IN_FIELDS_W-1:HANDLE_W+SIZE_W];
                        cur_reg        <= read_index_reg;
                        start_reg      <= read_index_reg;
                        state_reg      <= (cmd_t'(s_tuser[0]) == CMD_ADD) ? ST_ADD
                                                                          : ST_WALK;
                    end
                end
                ST_ADD: begin
                    if (out_free) begin
                        out_hit_reg            <= 1'b0;
                        out_slot_reg           <= '0;
                        out_handle_reg         <= '0;
                        out_offset_reg         <= '0;
                        out_evicted_reg        <= ring_full_reg;
                        out_evicted_handle_reg <= ring_full_reg ? rd_handle_reg : '0;
                        slot_valid_reg[write_index_reg] <= 1'b1;
                        write_index_reg        <= add_nxt;
                        if (!ring_full_reg) begin
                            if (add_nxt == read_index_reg) begin
                                ring_full_reg <= 1'b1;
                            end
                        end else begin
                            read_index_reg <= add_nxt;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_WALK: begin
                    if (step && !wrap) begin
                        off_reg <= off_reg - OFFSET_W'(rd_len_reg);
                        cur_reg <= nxt;
                    end else if (out_free) begin
                        // hit only when the walk stopped on a valid entry
                        out_hit_reg            <= !step && cur_valid;
                        out_slot_reg           <= (!step && cur_valid) ? SLOT_W'(cur_reg) : '0;
                        out_handle_reg         <= (!step && cur_valid) ? rd_handle_reg : '0;
                        out_offset_reg         <= (!step && cur_valid) ? SIZE_W'(off_reg)
                                                                       : '0;
                        out_evicted_reg        <= 1'b0;
                        out_evicted_handle_reg <= '0;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                       out_evicted_handle_reg, out_evicted_reg, out_offset_reg,
                       out_handle_reg, out_slot_reg, out_hit_reg};

endmodule

### hw/rtl/reslu_checker.sv
module reslu_checker import reslu_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one item at a time: ready drops after an accepted beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // a beat is either an add or a find result, never both
    a_hit_evict_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[53]))
        else $error("hit and evicted both set");

    // a miss or an add carries zero find fields
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[52:1] == '0)
        else $error("find fields nonzero without hit");

endmodule

bind ring_entry_store_offset_lookup reslu_checker u_reslu_checker (.*);
